/* rtl/dis_pkg.sv */
`timescale 1ns / 1ps
package dis_pkg;

    // defaults for the top-level parameters
    localparam int DEF_MAX_ENTRIES = 1024;
    localparam int DEF_KEY_BITS    = 16;

    // fixed field widths of the ports
    localparam int SKEY_W = 16;
    localparam int TAG_W  = 10;
    localparam int FILL_W = 11;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic ld_item;      // latch key and tag of the accepted word
        logic cnt_inc;
        logic cnt_dec;
        logic rd_top;       // read the entry at count-1, address register follows
        logic rd_next;      // read the entry below the current address
        logic wr_shift;     // move the entry just read up by one place
        logic wr_new_above; // write the new pair above the current address
        logic wr_new_zero;  // write the new pair at the bottom
        logic res_pop;      // result comes from the entry just read
        logic res_flag;     // result carries no pair
        logic res_drop;     // with res_flag: insert found the table full
        logic emit;         // move the result into the output register
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic empty;
        logic full;
        logic rd_ge;        // key just read is not below the new key
        logic addr_zero;
        logic out_free;
    } t_status;

endpackage

/* rtl/dis_ram.sv */
`timescale 1ns / 1ps
module dis_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/dis_datapath.sv */
`timescale 1ns / 1ps
module dis_datapath #(
    parameter int MAX_ENTRIES = dis_pkg::DEF_MAX_ENTRIES,
    parameter int KEY_BITS    = dis_pkg::DEF_KEY_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dis_pkg::t_cmd               i_cmd,
    output dis_pkg::t_status            o_status,
    input  logic [dis_pkg::SKEY_W-1:0]  i_sort_key,
    input  logic [dis_pkg::TAG_W-1:0]   i_entry_tag,
    input  logic                        i_out_ready,
    output logic                        o_out_word_valid,
    output logic [dis_pkg::SKEY_W-1:0]  o_out_key,
    output logic [dis_pkg::TAG_W-1:0]   o_out_tag,
    output logic                        o_out_valid,
    output logic                        o_dropped,
    output logic [dis_pkg::FILL_W-1:0]  o_fill_level
);
    import dis_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = KEY_BITS + TAG_W;

    logic [CW-1:0]       r_count;
    logic [AW-1:0]       r_addr;
    logic [KEY_BITS-1:0] r_key;
    logic [TAG_W-1:0]    r_tag;

    logic [SKEY_W-1:0]   r_res_key;
    logic [TAG_W-1:0]    r_res_tag;
    logic                r_res_valid;
    logic                r_res_drop;

    logic                r_ov;
    logic [SKEY_W-1:0]   r_o_key;
    logic [TAG_W-1:0]    r_o_tag;
    logic                r_o_valid;
    logic                r_o_drop;
    logic [FILL_W-1:0]   r_o_fill;

    logic [KEY_BITS+SKEY_W-1:0] in_key_wide;
    logic [KEY_BITS+SKEY_W-1:0] rd_key_wide;
    logic [CW+FILL_W-1:0]       fill_wide;
    logic [CW-1:0]              count_m1;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;
    logic [EW-1:0]              wr_data;
    logic [EW-1:0]              rd_data;
    logic [KEY_BITS-1:0]        rd_key;
    logic                       wr_en;
    logic                       rd_en;

    // key conversions between port width and stored width
    assign in_key_wide = {{KEY_BITS{1'b0}}, i_sort_key};
    assign rd_key      = rd_data[EW-1:TAG_W];
    assign rd_key_wide = {{SKEY_W{1'b0}}, rd_key};
    assign fill_wide   = {{FILL_W{1'b0}}, r_count};
    assign count_m1    = r_count - 1'b1;

    // memory addressing
    assign rd_en   = i_cmd.rd_top | i_cmd.rd_next;
    assign rd_addr = i_cmd.rd_top ? count_m1[AW-1:0] : r_addr - 1'b1;
    assign wr_en   = i_cmd.wr_shift | i_cmd.wr_new_above | i_cmd.wr_new_zero;
    assign wr_addr = i_cmd.wr_new_zero ? '0 : r_addr + 1'b1;
    assign wr_data = i_cmd.wr_shift ? rd_data : {r_key, r_tag};

    // entries sit in ascending key order, the largest at count-1
    dis_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // status
    assign o_status.empty     = (r_count == '0);
    assign o_status.full      = (r_count == CW'(MAX_ENTRIES));
    assign o_status.rd_ge     = (rd_key >= r_key);
    assign o_status.addr_zero = (r_addr == '0);
    assign o_status.out_free  = !r_ov || i_out_ready;

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + 1'b1;
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - 1'b1;
        end
    end

    // held item and walk address
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_key <= in_key_wide[KEY_BITS-1:0];
            r_tag <= i_entry_tag;
        end
        if (i_cmd.rd_top) begin
            r_addr <= count_m1[AW-1:0];
        end else if (i_cmd.rd_next) begin
            r_addr <= r_addr - 1'b1;
        end
    end

    // result staging
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_pop) begin
            r_res_key   <= rd_key_wide[SKEY_W-1:0];
            r_res_tag   <= rd_data[TAG_W-1:0];
            r_res_valid <= 1'b1;
            r_res_drop  <= 1'b0;
        end else if (i_cmd.res_flag) begin
            r_res_key   <= '0;
            r_res_tag   <= '0;
            r_res_valid <= 1'b0;
            r_res_drop  <= i_cmd.res_drop;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_key   <= r_res_key;
            r_o_tag   <= r_res_tag;
            r_o_valid <= r_res_valid;
            r_o_drop  <= r_res_drop;
            r_o_fill  <= fill_wide[FILL_W-1:0];
        end
    end

    assign o_out_word_valid = r_ov;
    assign o_out_key        = r_o_key;
    assign o_out_tag        = r_o_tag;
    assign o_out_valid      = r_o_valid;
    assign o_dropped        = r_o_drop;
    assign o_fill_level     = r_o_fill;

endmodule

/* rtl/dis_controller.sv */
`timescale 1ns / 1ps
module dis_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_operation,
    output logic             o_ready,
    input  dis_pkg::t_status i_status,
    output dis_pkg::t_cmd    o_cmd
);
    import dis_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_PLACE = 3'd2;
    localparam logic [2:0] S_POPRD = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.ld_item = 1'b1;
                    if (i_operation == OP_INSERT) begin
                        if (i_status.full) begin
                            o_cmd.res_flag = 1'b1;
                            o_cmd.res_drop = 1'b1;
                            n_state        = S_EMIT;
                        end else if (i_status.empty) begin
                            o_cmd.cnt_inc = 1'b1;
                            n_state       = S_PLACE;
                        end else begin
                            o_cmd.cnt_inc = 1'b1;
                            o_cmd.rd_top  = 1'b1;
                            n_state       = S_SHIFT;
                        end
                    end else begin
                        if (i_status.empty) begin
                            o_cmd.res_flag = 1'b1;
                            n_state        = S_EMIT;
                        end else begin
                            o_cmd.cnt_dec = 1'b1;
                            o_cmd.rd_top  = 1'b1;
                            n_state       = S_POPRD;
                        end
                    end
                end
            end
            // walk down from the top, moving every key not below the new one up
            S_SHIFT: begin
                if (i_status.rd_ge) begin
                    o_cmd.wr_shift = 1'b1;
                    if (i_status.addr_zero) begin
                        n_state = S_PLACE;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                    end
                end else begin
                    o_cmd.wr_new_above = 1'b1;
                    o_cmd.res_flag     = 1'b1;
                    n_state            = S_EMIT;
                end
            end
            S_PLACE: begin
                o_cmd.wr_new_zero = 1'b1;
                o_cmd.res_flag    = 1'b1;
                n_state           = S_EMIT;
            end
            S_POPRD: begin
                o_cmd.res_pop = 1'b1;
                n_state       = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/descending_insertion_sorter.sv */
`timescale 1ns / 1ps
// Sorted table of (key, tag) pairs; pops return the largest key first,
// equal keys in arrival order.
// Input channel: i_valid / o_ready with i_operation (0 insert, 1 pop),
// i_sort_key and i_entry_tag. One word is taken at a time; o_ready is
// high only while no word is in progress.
// Output channel: o_valid / i_ready, one result word per input word, with
// o_out_key, o_out_tag, o_out_valid, o_dropped and o_fill_level.
// An empty pop or a dropped insert goes straight to its result, a pop
// reads the top entry first, and an insert moves every stored entry not
// below its key up one place before writing its pair. o_ready comes back
// together with o_valid, so no word is taken before the last one's result
// is registered. The insert walk moves one entry per cycle through the
// single write port of the table memory, which sets the worst-case rate.
// Reset clears the entry count and the output valid flag; the memory itself
// needs no clearing. A result that waits on a stalled receiver sits in the
// output register while the next word is already taken and worked on; that
// word's result waits until the register is free.
module descending_insertion_sorter #(
    parameter int MAX_ENTRIES = dis_pkg::DEF_MAX_ENTRIES,
    parameter int KEY_BITS    = dis_pkg::DEF_KEY_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_operation,
    input  logic [dis_pkg::SKEY_W-1:0] i_sort_key,
    input  logic [dis_pkg::TAG_W-1:0]  i_entry_tag,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [dis_pkg::SKEY_W-1:0] o_out_key,
    output logic [dis_pkg::TAG_W-1:0]  o_out_tag,
    output logic                       o_out_valid,
    output logic                       o_dropped,
    output logic [dis_pkg::FILL_W-1:0] o_fill_level
);
    import dis_pkg::*;

    t_cmd    cmd;
    t_status status;

    dis_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .o_ready     (o_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    dis_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_sort_key       (i_sort_key),
        .i_entry_tag      (i_entry_tag),
        .i_out_ready      (i_ready),
        .o_out_word_valid (o_valid),
        .o_out_key        (o_out_key),
        .o_out_tag        (o_out_tag),
        .o_out_valid      (o_out_valid),
        .o_dropped        (o_dropped),
        .o_fill_level     (o_fill_level)
    );

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(MAX_ENTRIES);

    // a result never carries both a pair and a drop
    a_pop_not_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_out_valid && o_dropped))
        else $error("result flags both a popped pair and a drop");

    // a result without a pair carries zero key and tag
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out_valid) |-> (o_out_key == '0 && o_out_tag == '0))
        else $error("result without a pair has a nonzero payload");

    // a drop only happens at a full table
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dropped) |-> (o_fill_level == FILL_FULL))
        else $error("insert dropped while the table was not full");

    // no word is taken while a result is being produced
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit || cmd.res_pop || cmd.rd_next) |-> !o_ready)
        else $error("input taken while a word is in progress");

endmodule
